@@ sv/pwg_pkg.sv @@
// Shared types, constants and helper functions of the parametric waypoint generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pwg_pkg;

  localparam int unsigned MAX_POINTS = 65536;

  localparam int IDX_W      = 16;
  localparam int POS_W      = 32;
  localparam int QUAT_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Pipeline split: input multipliers, CORDIC/divider core, output stages
  localparam int FRONT_STAGES = 4;
  localparam int CORE_STAGES  = 8;
  localparam int BACK_STAGES  = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + CORE_STAGES + BACK_STAGES;

  localparam logic [29:0]        INV_TWO_PI_Q32  = 30'd683565276;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic [31:0]        ONE_EIGHTH_TURN = 32'h2000_0000;
  localparam logic signed [17:0] ONE_Q16         = 18'sd65536;

  typedef enum logic [1:0] {
    MODE_CIRCLE,
    MODE_HELIX,
    MODE_LINE,
    MODE_RAMP
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_RADIUS,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_BASE_Z,
    REG_STEP
  } reg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] radius;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] base_z;
    logic signed [31:0] step;
  } cfg_t;

  // One CORDIC rotator: Q30 vector, turn-count residue, fold flag
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  // Per-item payload carried through the core stages
  typedef struct packed {
    logic        neg;    // sign of step * index
    logic [46:0] absp;   // magnitude of step * index
    logic [45:0] hq;     // helix height magnitude
    cordic_t     ca;     // position angle
    cordic_t     cb;     // half-yaw angle
    logic [63:0] d1;     // dividend / quotient shift register, lane 1
    logic [63:0] d2;     // dividend / quotient shift register, lane 2
    logic [3:0]  r1;
    logic [3:0]  r2;
  } lane_t;

  // One decimal long-division digit step: returns {quotient nibble, remainder}
  function automatic logic [7:0] div10_step(input logic [3:0] r, input logic [3:0] nib);
    logic [7:0]  v;
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  rem;
    v    = {r, nib};
    prod = 16'(v) * 16'd205;
    q    = prod[14:11];
    rem  = v - 8'(q) * 8'd10;
    return {q, rem[3:0]};
  endfunction

  // atan(2^-i) as a 32-bit turn count
  function automatic logic signed [33:0] stage_angle(input int i);
    logic signed [33:0] a;
    case (i)
      0:       a = 34'sd536870912;
      1:       a = 34'sd316933406;
      2:       a = 34'sd167458907;
      3:       a = 34'sd85004756;
      4:       a = 34'sd42667331;
      5:       a = 34'sd21354465;
      6:       a = 34'sd10679838;
      7:       a = 34'sd5340245;
      8:       a = 34'sd2670163;
      9:       a = 34'sd1335087;
      10:      a = 34'sd667544;
      11:      a = 34'sd333772;
      12:      a = 34'sd166886;
      13:      a = 34'sd83443;
      14:      a = 34'sd41722;
      15:      a = 34'sd20861;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ sv/pwg_if.sv @@
// Valid/ready channel interfaces of the waypoint generator: request, pose, setup.
// Depends on pwg_pkg for the field widths.
`default_nettype none

interface pwg_req_if import pwg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] point_index;
  modport source (output valid, point_index, input ready);
  modport sink   (input valid, point_index, output ready);
endinterface

interface pwg_pose_if import pwg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_z;
  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_z, output ready);
endinterface

interface pwg_cfg_if import pwg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/pwg_front.sv @@
// Front stages: angle product, phase and helix partial products, divider load, CORDIC fold.
// Depends on pwg_pkg.
`default_nettype none

module pwg_front import pwg_pkg::*; (
  input  wire logic                    clk,
  input  wire cfg_t                    cfg,
  input  wire logic [FRONT_STAGES-1:0] en,
  input  wire logic [IDX_W-1:0]        idx,
  output lane_t                        lane_out
);

  // Stage 0 registers
  logic signed [48:0] p0;
  logic [IDX_W-1:0]   idx0;
  // Stage 1 registers
  logic [54:0]        pp_hi;
  logic [53:0]        pp_lo;
  logic [52:0]        hm;
  logic [53:0]        lm;
  logic               neg1;
  logic [46:0]        absp1;
  logic [IDX_W-1:0]   idx1;
  // Stage 2 registers
  logic [31:0]        phase2;
  logic [31:0]        half2;
  logic [45:0]        hq2;
  logic               neg2;
  logic [46:0]        absp2;
  logic [63:0]        d1_2;
  logic [63:0]        d2_2;

  logic [IDX_W-1:0]   idx_c;
  logic signed [48:0] p_c;
  logic [46:0]        absp_c;
  logic [48:0]        wide_c;
  logic [53:0]        hsum_c;
  logic [63:0]        d1_c;
  lane_t              lane_c;

  // Fold a turn count into a quarter turn around zero, start the rotator
  function automatic cordic_t fold(input logic [31:0] phase);
    cordic_t c;
    logic signed [33:0] z;
    z      = 34'($signed(phase));
    c.flip = 1'b0;
    if (z > 34'sd1073741824) begin
      z      = z - 34'sd2147483648;
      c.flip = 1'b1;
    end else if (z < -34'sd1073741824) begin
      z      = z + 34'sd2147483648;
      c.flip = 1'b1;
    end
    c.x = CORDIC_GAIN_Q30;
    c.y = 32'sd0;
    c.z = z;
    return c;
  endfunction

  // Stage 0: clamp index, form step * index
  always_comb begin
    idx_c = (32'(idx) > 32'(MAX_POINTS - 1)) ? IDX_W'(MAX_POINTS - 1) : idx;
    p_c   = 49'(cfg.step) * 49'($signed({1'b0, idx_c}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0   <= p_c;
      idx0 <= idx_c;
    end
  end

  // Stage 1: split products for the phase and the helix height
  assign absp_c = p0[48] ? 47'(-p0) : 47'(p0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp_hi <= 55'(p0[48:24]) * 55'(INV_TWO_PI_Q32);
      pp_lo <= 54'(p0[23:0]) * 54'(INV_TWO_PI_Q32);
      hm    <= 53'(absp_c[46:24]) * 53'(INV_TWO_PI_Q32);
      lm    <= 54'(absp_c[23:0]) * 54'(INV_TWO_PI_Q32);
      neg1  <= p0[48];
      absp1 <= absp_c;
      idx1  <= idx0;
    end
  end

  // Stage 2: combine partial products, pick divider operands
  always_comb begin
    wide_c = 49'({pp_hi, 24'b0}) + 49'(pp_lo);
    hsum_c = 54'(hm) + 54'(lm >> 24);
    if (cfg.mode == MODE_RAMP) begin
      d1_c = {16'b0, idx1, 32'b0} >> 16;
    end else begin
      d1_c = 64'(absp1) + 64'({absp1, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      phase2 <= wide_c[47:16];
      half2  <= wide_c[48:17] + ONE_EIGHTH_TURN;
      hq2    <= hsum_c[53:8];
      neg2   <= neg1;
      absp2  <= absp1;
      d1_2   <= d1_c;
      d2_2   <= 64'(absp1);
    end
  end

  // Stage 3: fold both angles, hand the lane to the core
  always_comb begin
    lane_c.neg  = neg2;
    lane_c.absp = absp2;
    lane_c.hq   = hq2;
    lane_c.ca   = fold(phase2);
    lane_c.cb   = fold(half2);
    lane_c.d1   = d1_2;
    lane_c.d2   = d2_2;
    lane_c.r1   = 4'd0;
    lane_c.r2   = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lane_out <= lane_c;
    end
  end

endmodule

`default_nettype wire

@@ sv/pwg_core.sv @@
// Core stages: two CORDIC iterations for both angles and two divide-by-ten digits per stage.
// Depends on pwg_pkg.
`default_nettype none

module pwg_core import pwg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic [CORE_STAGES-1:0] en,
  input  wire lane_t                  lane_in,
  output lane_t                       lane_out
);

  lane_t lane_q [CORE_STAGES];

  // One rotation toward zero residue
  function automatic cordic_t cordic_iter(input cordic_t c, input int sh,
                                          input logic signed [33:0] ang);
    cordic_t r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    dx = c.y >>> sh;
    dy = c.x >>> sh;
    r  = c;
    if (!c.z[33]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ang;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ang;
    end
    return r;
  endfunction

  for (genvar g = 0; g < CORE_STAGES; g++) begin : g_stage
    lane_t      cur;
    lane_t      nxt;
    logic [7:0] s1a;
    logic [7:0] s1b;
    logic [7:0] s2a;
    logic [7:0] s2b;

    if (g == 0) begin : g_first
      assign cur = lane_in;
    end else begin : g_rest
      assign cur = lane_q[g-1];
    end

    // Advance both rotators and both long divisions
    always_comb begin
      nxt    = cur;
      nxt.ca = cordic_iter(cordic_iter(cur.ca, 2*g, stage_angle(2*g)),
                           2*g + 1, stage_angle(2*g + 1));
      nxt.cb = cordic_iter(cordic_iter(cur.cb, 2*g, stage_angle(2*g)),
                           2*g + 1, stage_angle(2*g + 1));
      s1a    = div10_step(cur.r1, cur.d1[63:60]);
      s1b    = div10_step(s1a[3:0], cur.d1[59:56]);
      s2a    = div10_step(cur.r2, cur.d2[63:60]);
      s2b    = div10_step(s2a[3:0], cur.d2[59:56]);
      nxt.d1 = {cur.d1[55:0], s1a[7:4], s1b[7:4]};
      nxt.d2 = {cur.d2[55:0], s2a[7:4], s2b[7:4]};
      nxt.r1 = s1b[3:0];
      nxt.r2 = s2b[3:0];
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        lane_q[g] <= nxt;
      end
    end
  end

  assign lane_out = lane_q[CORE_STAGES-1];

endmodule

`default_nettype wire

@@ sv/pwg_back.sv @@
// Output stages: radius scaling, quaternion terms, per-mode selection and saturation.
// Depends on pwg_pkg.
`default_nettype none

module pwg_back import pwg_pkg::*; (
  input  wire logic                   clk,
  input  wire cfg_t                   cfg,
  input  wire logic [BACK_STAGES-1:0] en,
  input  wire lane_t                  lane_in,
  output logic signed [POS_W-1:0]     pos_x,
  output logic signed [POS_W-1:0]     pos_y,
  output logic signed [POS_W-1:0]     pos_z,
  output logic signed [QUAT_W-1:0]    quat_w,
  output logic signed [QUAT_W-1:0]    quat_z
);

  // Stage 0 registers
  logic signed [63:0]       prod_x;
  logic signed [63:0]       prod_y;
  logic signed [QUAT_W-1:0] qw1;
  logic signed [QUAT_W-1:0] qz1;
  logic                     neg1;
  logic [46:0]              absp1;
  logic [45:0]              hq1;
  logic [46:0]              q1;
  logic [46:0]              q2;

  logic signed [31:0]       cx;
  logic signed [31:0]       cy;
  logic signed [31:0]       cw;
  logic signed [31:0]       cz;

  logic signed [65:0]       sum_x;
  logic signed [65:0]       sum_y;
  logic signed [65:0]       sum_z;
  logic signed [65:0]       mag_h;
  logic signed [65:0]       mag_x;
  logic signed [65:0]       mag_y;
  logic signed [65:0]       mag_z;
  logic signed [POS_W-1:0]  px_c;
  logic signed [POS_W-1:0]  py_c;
  logic signed [POS_W-1:0]  pz_c;
  logic signed [QUAT_W-1:0] qw_c;
  logic signed [QUAT_W-1:0] qz_c;

  function automatic logic signed [QUAT_W-1:0] sat18(input logic signed [31:0] v);
    logic signed [QUAT_W-1:0] r;
    if (v > 32'sd131071) begin
      r = 18'sd131071;
    end else if (v < -32'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = 18'(v);
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Stage 0: undo the fold, scale by radius, quaternion terms
  always_comb begin
    cx = lane_in.ca.flip ? -lane_in.ca.x : lane_in.ca.x;
    cy = lane_in.ca.flip ? -lane_in.ca.y : lane_in.ca.y;
    cw = lane_in.cb.flip ? -lane_in.cb.x : lane_in.cb.x;
    cz = lane_in.cb.flip ? -lane_in.cb.y : lane_in.cb.y;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x <= 64'(cfg.radius) * 64'(cx);
      prod_y <= 64'(cfg.radius) * 64'(cy);
      qw1    <= sat18(cw >>> 14);
      qz1    <= sat18(cz >>> 14);
      neg1   <= lane_in.neg;
      absp1  <= lane_in.absp;
      hq1    <= lane_in.hq;
      q1     <= lane_in.d1[46:0];
      q2     <= lane_in.d2[46:0];
    end
  end

  // Stage 1: select per mode, add offsets, saturate
  always_comb begin
    mag_h = $signed(66'(hq1));
    mag_x = $signed(66'(absp1 >> 1));
    mag_y = $signed(66'(q1));
    mag_z = $signed(66'(q2));
    sum_x = 66'(prod_x >>> 30) + 66'(cfg.org_x);
    sum_y = 66'(prod_y >>> 30) + 66'(cfg.org_y);
    sum_z = neg1 ? -mag_h : mag_h;
    px_c  = '0;
    py_c  = '0;
    pz_c  = '0;
    qw_c  = ONE_Q16;
    qz_c  = '0;
    case (cfg.mode)
      MODE_CIRCLE, MODE_HELIX: begin
        px_c = sat32(sum_x);
        py_c = sat32(sum_y);
        pz_c = (cfg.mode == MODE_CIRCLE) ? cfg.base_z : sat32(sum_z);
        qw_c = qw1;
        qz_c = qz1;
      end
      MODE_LINE: begin
        px_c = sat32(66'(cfg.org_x) + (neg1 ? -mag_x : mag_x));
        py_c = sat32(66'(cfg.org_y) + (neg1 ? -mag_y : mag_y));
        pz_c = sat32(66'(cfg.base_z) + (neg1 ? -mag_z : mag_z));
      end
      MODE_RAMP: begin
        px_c = $signed(q1[31:0]);
      end
      default: begin
        px_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos_x  <= px_c;
      pos_y  <= py_c;
      pos_z  <= pz_c;
      quat_w <= qw_c;
      quat_z <= qz_c;
    end
  end

endmodule

`default_nettype wire

@@ sv/parametric_waypoint_generator.sv @@
// Top level of the parametric waypoint generator: setup registers, stage valid chain.
// Depends on pwg_pkg, pwg_if, pwg_front, pwg_core and pwg_back.
//
// Each request beat carries a waypoint index and yields one pose beat
// (position x, y, z in Q15.16 and yaw quaternion w, z in Q1.16), in order.
// The block takes one request per cycle and delivers one pose per cycle
// while the pose side is ready. The pipeline is made up of the
// 16-iteration CORDIC, run two iterations per stage over eight stages, plus
// four stages of angle and phase multipliers and two of radius scaling and
// saturation. Stages hold under back-pressure and empty stages fill, so a
// stalled pose does not block new requests until the pipeline is full.
// Setup registers may be written only while no request is in flight.
`default_nettype none

module parametric_waypoint_generator import pwg_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  pwg_req_if.sink     request,
  pwg_pose_if.source  pose,
  pwg_cfg_if.sink     setup
);

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] rdy;
  lane_t                 front_lane;
  lane_t                 core_lane;

  // Setup register writes; unknown indexes are dropped
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_CIRCLE;
      cfg.radius   <= 32'sd65536;
      cfg.org_x    <= 32'sd0;
      cfg.org_y    <= 32'sd0;
      cfg.base_z   <= 32'sd0;
      cfg.step     <= 32'sd6554;
    end else if (setup.valid && setup.ready) begin
      case (reg_idx_t'(setup.index))
        REG_MODE:     cfg.mode     <= mode_t'(setup.data[1:0]);
        REG_RADIUS:   cfg.radius   <= $signed(setup.data);
        REG_CENTER_X: cfg.org_x    <= $signed(setup.data);
        REG_CENTER_Y: cfg.org_y    <= $signed(setup.data);
        REG_BASE_Z:   cfg.base_z   <= $signed(setup.data);
        REG_STEP:     cfg.step     <= $signed(setup.data);
        default:      cfg.mode     <= cfg.mode;
      endcase
    end
  end

  // Stage advance: a stage loads when empty or when the next one loads
  assign rdy[NUM_STAGES-1] = !v[NUM_STAGES-1] || pose.ready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  assign request.ready = rdy[0];
  assign pose.valid    = v[NUM_STAGES-1];

  // Valid bits travel with the stage data
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        if (k == 0) begin
          v[k] <= request.valid;
        end else begin
          v[k] <= v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  pwg_front u_front (
    .clk      (clk),
    .cfg      (cfg),
    .en       (rdy[FRONT_STAGES-1:0]),
    .idx      (request.point_index),
    .lane_out (front_lane)
  );

  pwg_core u_core (
    .clk      (clk),
    .en       (rdy[FRONT_STAGES+CORE_STAGES-1:FRONT_STAGES]),
    .lane_in  (front_lane),
    .lane_out (core_lane)
  );

  pwg_back u_back (
    .clk     (clk),
    .cfg     (cfg),
    .en      (rdy[NUM_STAGES-1:FRONT_STAGES+CORE_STAGES]),
    .lane_in (core_lane),
    .pos_x   (pose.pos_x),
    .pos_y   (pose.pos_y),
    .pos_z   (pose.pos_z),
    .quat_w  (pose.quat_w),
    .quat_z  (pose.quat_z)
  );

`ifndef NO_ASSERTIONS
  // Request is refused only when every stage holds a beat
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (&v))
    else $error("request refused with an empty stage");

  // An accepted request beat occupies the first stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> v[0])
    else $error("accepted request beat lost at stage 0");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (v == '0))
    else $error("stage valid set after reset");

  // A stalled pose beat keeps the pipeline from losing a stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (pose.valid && !pose.ready) |=> pose.valid)
    else $error("stalled pose beat dropped");
`endif

endmodule

`default_nettype wire

@@ tb/parametric_waypoint_generator_tb.sv @@
// Self-checking bench for the parametric waypoint generator: drives index beats,
// predicts each pose in fixed point and compares it with the pose beats.
// Depends on pwg_pkg, the pwg_if interfaces and the generator top level.
`timescale 1ns / 1ps

module parametric_waypoint_generator_tb;
  import pwg_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG_MAX = 3000;
  localparam int SETTLE       = NUM_STAGES + 6;

  localparam longint TURN_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  localparam logic [IDX_W-1:0] CORNER_IDX [6] =
    '{16'd0, 16'd1, 16'd2, 16'hffff, 16'h8000, 16'h5a5a};

  typedef struct {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic signed [QUAT_W-1:0] qw;
    logic signed [QUAT_W-1:0] qz;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pwg_req_if  request();
  pwg_pose_if pose();
  pwg_cfg_if  setup();

  parametric_waypoint_generator dut (
    .clk(clk), .rst(rst), .request(request), .pose(pose), .setup(setup)
  );

  // Shadow copy of the setup registers
  mode_t              path_mode  = MODE_CIRCLE;
  logic signed [31:0] path_radius = 32'sd65536;
  logic signed [31:0] path_cx    = '0;
  logic signed [31:0] path_cy    = '0;
  logic signed [31:0] path_bz    = '0;
  logic signed [31:0] path_step  = 32'sd6554;

  logic [IDX_W-1:0] index_backlog [$];
  pose_t            pose_pending  [$];

  int  mismatches = 0;
  int  idle_pct   = 0;
  bit  calm       = 1'b0;
  bit  hold_go    = 1'b0;
  int  hold_cnt   = 0;
  int  send_gap   = 0;
  int  recv_gap   = 0;
  int  quiet_cnt  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [17:0] sat18(input longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return 18'(v);
  endfunction

  // cos/sin in Q30 of a 32-bit turn count
  function automatic void rotate(input logic [31:0] phase, output longint c,
                                 output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    z = longint'($signed(phase));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= TURN_ANGLE[i];
      end else begin
        x += dx; y -= dy; z += TURN_ANGLE[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Pose of one waypoint under the current path setup
  function automatic pose_t waypoint_pose(input logic [IDX_W-1:0] idx);
    pose_t  r;
    longint p, c, s, m, q;
    logic [63:0] wide;
    logic [31:0] half;
    p = longint'(path_step) * longint'({1'b0, idx});
    r.qw = ONE_Q16;
    r.qz = '0;
    case (path_mode)
      MODE_CIRCLE, MODE_HELIX: begin
        wide = 64'(p) * 64'd683565276;
        half = 32'(wide >> 17) + 32'h2000_0000;
        rotate(wide[47:16], c, s);
        r.x = sat32(((longint'(path_radius) * c) >>> 30) + longint'(path_cx));
        r.y = sat32(((longint'(path_radius) * s) >>> 30) + longint'(path_cy));
        if (path_mode == MODE_CIRCLE) begin
          r.z = path_bz;
        end else begin
          m = (p < 0) ? -p : p;
          q = ((m >> 24) * 683565276 + (((m & 64'hFFFFFF) * 683565276) >> 24)) >> 8;
          r.z = sat32((p < 0) ? -q : q);
        end
        rotate(half, c, s);
        r.qw = sat18(c >>> 14);
        r.qz = sat18(s >>> 14);
      end
      MODE_LINE: begin
        r.x = sat32(longint'(path_cx) + (p * 5) / 10);
        r.y = sat32(longint'(path_cy) + (p * 3) / 10);
        r.z = sat32(longint'(path_bz) + p / 10);
      end
      default: begin
        r.x = 32'((longint'({1'b0, idx}) * 65536) / 10);
        r.y = '0;
        r.z = '0;
      end
    endcase
    return r;
  endfunction

  // Request driver: offer backlog entries, with random gaps
  always @(posedge clk) begin
    logic nxt_valid;
    logic [IDX_W-1:0] nxt_idx;
    nxt_valid = request.valid;
    nxt_idx   = request.point_index;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (request.valid && request.ready) begin
        pose_pending.insert(pose_pending.size(), waypoint_pose(request.point_index));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
          send_gap = $urandom_range(1, 17) - 1;
        end else if (index_backlog.size() > 0) begin
          nxt_idx   = index_backlog.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    request.valid       <= nxt_valid;
    request.point_index <= nxt_idx;
  end

  // Pose monitor: check each beat, stall at random, hold off on request
  always @(posedge clk) begin
    pose_t want;
    logic  nxt_ready;
    if (rst) begin
      nxt_ready = 1'b0;
    end else begin
      if (pose.valid && pose.ready) begin
        if (pose_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose beat x=%0d", pose.pos_x);
        end else begin
          want = pose_pending.pop_front();
          if (pose.pos_x !== want.x || pose.pos_y !== want.y || pose.pos_z !== want.z ||
              pose.quat_w !== want.qw || pose.quat_z !== want.qz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                       want.x, want.y, want.z, want.qw, want.qz,
                       pose.pos_x, pose.pos_y, pose.pos_z, pose.quat_w, pose.quat_z);
          end
        end
      end
      nxt_ready = 1'b1;
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else if (!calm && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        recv_gap  = $urandom_range(1, 17) - 1;
        nxt_ready = 1'b0;
      end
    end
    pose.ready <= nxt_ready;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (pose.valid && pose.ready) ||
        (setup.valid && setup.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Write one setup register and mirror it; valid stays up for the next write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    setup.valid <= 1'b1;
    setup.index <= idx;
    setup.data  <= value;
    do @(posedge clk); while (!setup.ready);
    case (idx)
      REG_MODE:     path_mode   = mode_t'(value[1:0]);
      REG_RADIUS:   path_radius = value;
      REG_CENTER_X: path_cx     = value;
      REG_CENTER_Y: path_cy     = value;
      REG_BASE_Z:   path_bz     = value;
      REG_STEP:     path_step   = value;
      default: ;
    endcase
  endtask

  // Drop setup valid after the last write of a group
  task automatic idle_setup();
    setup.valid <= 1'b0;
  endtask

  task automatic drain();
    while (index_backlog.size() > 0 || pose_pending.size() > 0 || request.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Q15.16 value biased toward the extremes
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      4: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(3))
      0: return IDX_W'($urandom_range(0, 63));
      1: return 16'hffff - IDX_W'($urandom_range(0, 3));
      default: return IDX_W'($urandom);
    endcase
  endfunction

  initial begin
    request.valid = 1'b0;
    request.point_index = '0;
    pose.ready = 1'b0;
    setup.valid = 1'b0;
    setup.index = '0;
    setup.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each mode at the corner indexes, with saturating setups
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(REG_MODE, {30'h3fff_fffc >> m, 2'(m)});
      write_reg(REG_STEP, (m % 2) ? 32'h7fff_ffff : 32'h8000_0000);
      write_reg(REG_RADIUS, (m == 1) ? 32'h8000_0000 : 32'h7fff_ffff);
      write_reg(REG_CENTER_X, (m == 0) ? 32'h7fff_ffff : 32'h8000_0000);
      write_reg(REG_CENTER_Y, (m == 2) ? 32'h7fff_ffff : 32'h0000_8000);
      write_reg(REG_BASE_Z, (m == 2) ? 32'h8000_0000 : 32'h0001_0000);
      idle_setup();
      for (int k = 0; k < 6; k++) index_backlog.insert(index_backlog.size(), CORNER_IDX[k]);
    end

    // Random setups, the first with a long receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(3'd6 + 3'(ph % 2), $urandom);
      write_reg(REG_MODE, {$urandom} & 32'hffff_fffc | (ph % 4));
      write_reg(REG_RADIUS, pick_q16());
      write_reg(REG_CENTER_X, pick_q16());
      write_reg(REG_CENTER_Y, pick_q16());
      write_reg(REG_BASE_Z, pick_q16());
      write_reg(REG_STEP, pick_q16());
      idle_setup();
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 35);
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < 85; k++) index_backlog.insert(index_backlog.size(), pick_index());
      if (ph == 0) hold_go = 1'b1;
    end

    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
